>>> hdl/arq_pkg.sv
// Shared types and constants for the ARQ retransmission table.
// Used by the controller, the datapath, the top level and the checker.
package arq_pkg;

  localparam int DEF_SEQ_BITS  = 8;
  localparam int DEF_TIME_BITS = 32;

  // Command codes of an input word.
  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_ACK   = 3'd1;
  localparam logic [2:0] CMD_NAK   = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_POLL  = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  // Action codes of a result word.
  localparam logic [2:0] ACT_NAK          = 3'd0;
  localparam logic [2:0] ACT_TIMEOUT      = 3'd1;
  localparam logic [2:0] ACT_GIVEUP_BASE  = 3'd2;
  localparam logic [2:0] ACT_GIVEUP_OTHER = 3'd3;
  localparam logic [2:0] ACT_NONE         = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PORT   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_TIMEOUT     = 16'd500;
  localparam logic [3:0]  RST_MAX_RETRIES = 4'd3;
  localparam logic [15:0] RST_BASE_PORT   = 16'd9000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } arq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word and start the table read
    logic commit;    // write back the entry and load the result register
    logic clr_init;  // restart the clearing pass and the sweep pointer
    logic clr_step;  // clear one table entry
  } arq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_clear;
    logic res_needed;
    logic out_busy;
    logic clr_last;
  } arq_status_t;

endpackage

>>> hdl/arq_retransmit_table_top.sv
// Top level of the ARQ retransmission table.
// Instantiates arq_ctrl and arq_dp; depends on arq_pkg.

// Each word other than a table clear goes through an accept step, which takes it and
// starts the read of its entry in the single-port table memory, and an update step,
// which updates that entry and loads the result register. A result that finds the
// result register still stalled holds the block until it can be loaded, while
// a result already waiting there does not stop the next word from being
// accepted. After reset and after each clear table word the block runs a
// clearing pass over all 2**SEQ_BITS entries (256 by default), one entry a cycle,
// during which in_stall stays high; configuration writes are taken meanwhile.
module arq_retransmit_table_top import arq_pkg::*; #(
  parameter int SEQ_BITS  = DEF_SEQ_BITS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_cmd,
  input  logic [7:0]            in_seq,
  input  logic [15:0]           in_packet_handle,
  input  logic [15:0]           in_recipient_port,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_seq,
  output logic [15:0]           out_handle,
  output logic [15:0]           out_port,
  output logic [2:0]            out_action,
  output logic                  out_sweep_end
);

  arq_cmd_t    cmd;
  arq_status_t st;

  arq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  arq_dp #(
    .SEQ_BITS  (SEQ_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_cmd            (in_cmd),
    .in_seq            (in_seq),
    .in_packet_handle  (in_packet_handle),
    .in_recipient_port (in_recipient_port),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_seq           (out_seq),
    .out_handle        (out_handle),
    .out_port          (out_port),
    .out_action        (out_action),
    .out_sweep_end     (out_sweep_end)
  );

endmodule

>>> hdl/arq_ctrl.sv
// Controller state machine for the ARQ retransmission table.
// Depends on arq_pkg for the state, command and status types.
module arq_ctrl import arq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  arq_status_t st,
  output arq_cmd_t    cmd
);

  arq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (st.in_is_clear) begin
            cmd.clr_init = 1'b1;
            state_nxt    = ST_CLEAR;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        // A result waits here until the output register can take it.
        if (!st.res_needed || !st.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/arq_dp.sv
// Datapath of the ARQ retransmission table: entry memory, clock, sweep
// pointer, configuration registers and result register. Depends on arq_pkg.
module arq_dp import arq_pkg::*; #(
  parameter int SEQ_BITS  = DEF_SEQ_BITS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  arq_cmd_t              cmd,
  output arq_status_t           st,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [2:0]            in_cmd,
  input  logic [7:0]            in_seq,
  input  logic [15:0]           in_packet_handle,
  input  logic [15:0]           in_recipient_port,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_seq,
  output logic [15:0]           out_handle,
  output logic [15:0]           out_port,
  output logic [2:0]            out_action,
  output logic                  out_sweep_end
);

  localparam int DEPTH = 1 << SEQ_BITS;
  // Compare width covers both the age and the largest backed-off timeout.
  localparam int CMP_W = (TIME_BITS > 31) ? TIME_BITS : 31;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] sent;
    logic [3:0]           retries;
    logic [15:0]          port;
    logic [15:0]          handle;
  } entry_t;

  entry_t mem [DEPTH];

  // Configuration registers.
  logic        running_r, role_base_r;
  logic [15:0] timeout_r, base_port_r;
  logic [3:0]  max_retries_r;

  // Control state.
  logic [TIME_BITS-1:0] time_r;
  logic [SEQ_BITS-1:0]  sweep_r, clr_cnt_r;
  logic                 out_valid_r;

  // Captured input word and the entry read for it.
  logic [2:0]          cmd_r;
  logic [SEQ_BITS-1:0] addr_r;
  logic [15:0]         handle_r, port_r;
  entry_t              rd_r;

  // Result register payload.
  logic [7:0]  out_seq_r;
  logic [15:0] out_handle_r, out_port_r;
  logic [2:0]  out_action_r;
  logic        out_end_r;

  logic [SEQ_BITS+7:0]  seq_ext, addr_ext;
  logic [SEQ_BITS-1:0]  in_addr, rd_addr;
  logic [TIME_BITS-1:0] age;
  logic [CMP_W-1:0]     age_w, limit_w;
  logic                 timed_out;

  logic        res_valid, wr_en;
  entry_t      wr_data;
  logic [15:0] res_handle, res_port;
  logic [2:0]  res_action;
  logic        res_end;

  assign seq_ext  = {{SEQ_BITS{1'b0}}, in_seq};
  assign in_addr  = seq_ext[SEQ_BITS-1:0];
  assign rd_addr  = (in_cmd == CMD_POLL) ? sweep_r : in_addr;
  assign addr_ext = {8'd0, addr_r};

  assign age       = time_r - rd_r.sent;
  assign age_w     = CMP_W'(age);
  assign limit_w   = CMP_W'(timeout_r) << rd_r.retries;
  assign timed_out = age_w > limit_w;

  always_comb begin
    res_valid  = 1'b0;
    wr_en      = 1'b0;
    wr_data    = rd_r;
    res_handle = rd_r.handle;
    res_port   = rd_r.port;
    res_action = ACT_NONE;
    res_end    = 1'b0;
    case (cmd_r)
      CMD_ADD: begin
        if (running_r && !rd_r.valid) begin
          wr_en           = 1'b1;
          wr_data.valid   = 1'b1;
          wr_data.sent    = time_r;
          wr_data.retries = 4'd0;
          wr_data.port    = port_r;
          wr_data.handle  = handle_r;
        end
      end
      CMD_ACK: begin
        if (running_r && !role_base_r) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b0;
        end
      end
      CMD_NAK: begin
        if (running_r && role_base_r && rd_r.valid) begin
          res_valid  = 1'b1;
          res_action = ACT_NAK;
        end
      end
      CMD_POLL: begin
        if (running_r) begin
          res_valid = 1'b1;
          res_end   = (addr_r == {SEQ_BITS{1'b1}});
          if (rd_r.valid && !role_base_r && timed_out) begin
            wr_en = 1'b1;
            if (rd_r.retries >= max_retries_r) begin
              wr_data.valid = 1'b0;
              res_action = (rd_r.port == base_port_r) ? ACT_GIVEUP_BASE : ACT_GIVEUP_OTHER;
            end else begin
              wr_data.sent    = time_r;
              wr_data.retries = rd_r.retries + 4'd1;
              res_action      = ACT_TIMEOUT;
            end
          end else begin
            res_handle = 16'd0;
            res_port   = 16'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && wr_en) begin
      mem[addr_r] <= wr_data;
    end
    if (cmd.load) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      addr_r   <= rd_addr;
      handle_r <= in_packet_handle;
      port_r   <= in_recipient_port;
    end
    if (cmd.commit && res_valid) begin
      out_seq_r    <= addr_ext[7:0];
      out_handle_r <= res_handle;
      out_port_r   <= res_port;
      out_action_r <= res_action;
      out_end_r    <= res_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r     <= 1'b0;
      role_base_r   <= 1'b0;
      timeout_r     <= RST_TIMEOUT;
      max_retries_r <= RST_MAX_RETRIES;
      base_port_r   <= RST_BASE_PORT;
      time_r        <= '0;
      sweep_r       <= '0;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RUNNING:     running_r     <= cfg_data[0];
          CFG_ROLE_BASE:   role_base_r   <= cfg_data[0];
          CFG_TIMEOUT:     timeout_r     <= cfg_data;
          CFG_MAX_RETRIES: max_retries_r <= cfg_data[3:0];
          CFG_BASE_PORT:   base_port_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.clr_init) begin
        clr_cnt_r <= '0;
        sweep_r   <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        if (cmd_r == CMD_TICK) begin
          time_r <= time_r + 1'b1;
        end
        if (cmd_r == CMD_POLL && running_r) begin
          sweep_r <= addr_r + 1'b1;
        end
      end
      if (cmd.commit && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.in_is_clear = (in_cmd == CMD_CLEAR);
  assign st.res_needed  = res_valid;
  assign st.out_busy    = out_valid_r && out_stall;
  assign st.clr_last    = (clr_cnt_r == {SEQ_BITS{1'b1}});

  assign out_valid     = out_valid_r;
  assign out_seq       = out_seq_r;
  assign out_handle    = out_handle_r;
  assign out_port      = out_port_r;
  assign out_action    = out_action_r;
  assign out_sweep_end = out_end_r;

endmodule

>>> hdl/arq_checker.sv
// Port-level checker for the ARQ retransmission table, bound to the top level.
// Depends on arq_pkg for the action codes.
module arq_checker import arq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_seq,
  input logic [15:0] out_handle,
  input logic [15:0] out_port,
  input logic [2:0]  out_action,
  input logic        out_sweep_end
);

  // The clearing pass starts right after reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // Every accepted word occupies the block and stalls the input behind it.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted in back-to-back cycles");

  // A nak result never marks the end of a sweep.
  a_nak_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_NAK |-> !out_sweep_end)
    else $error("nak result with sweep end set");

  // A poll with nothing to do reports no handle and no port.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_NONE |-> out_handle == 16'd0 && out_port == 16'd0)
    else $error("idle poll result carries entry data");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seq) && $stable(out_action))
    else $error("stalled result word changed");

endmodule

bind arq_retransmit_table_top arq_checker u_arq_checker (.*);

>>> verif/tb_arq_retransmit_table_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for arq_retransmit_table_top: directed and random command words
// are checked against a behavioral model of the table kept in this file; depends on arq_pkg.
module tb_arq_retransmit_table_top;
  import arq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 8;

  // Command codes that the block defines no meaning for.
  localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [7:0]  seq;
    logic [15:0] handle;
    logic [15:0] port;
    logic [2:0]  action;
    logic        sweep_end;
  } result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            in_cmd;
  logic [7:0]            in_seq;
  logic [15:0]           in_packet_handle;
  logic [15:0]           in_recipient_port;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_seq;
  logic [15:0]           out_handle;
  logic [15:0]           out_port;
  logic [2:0]            out_action;
  logic                  out_sweep_end;

  // Model of the table and its registers.
  logic        tbl_valid [256];
  logic [31:0] tbl_sent [256];
  logic [3:0]  tbl_retries [256];
  logic [15:0] tbl_port [256];
  logic [15:0] tbl_handle [256];
  logic [31:0] clock_ms;
  logic [7:0]  sweep_ptr;
  logic        run_m;
  logic        base_m;
  logic [15:0] timeout_m;
  logic [3:0]  max_retries_m;
  logic [15:0] base_port_m;

  result_t     due_results[$];
  logic [7:0]  recent_seqs[$];
  result_t     got_exp;
  int          err_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          seg_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  arq_retransmit_table_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_seq(in_seq),
    .in_packet_handle(in_packet_handle), .in_recipient_port(in_recipient_port),
    .out_valid(out_valid), .out_stall(out_stall), .out_seq(out_seq),
    .out_handle(out_handle), .out_port(out_port), .out_action(out_action),
    .out_sweep_end(out_sweep_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void model_reset();
    for (int i = 0; i < 256; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_sent[i] = '0;
      tbl_retries[i] = '0;
      tbl_port[i] = '0;
      tbl_handle[i] = '0;
    end
    clock_ms = '0;
    sweep_ptr = '0;
    run_m = 1'b0;
    base_m = 1'b0;
    timeout_m = RST_TIMEOUT;
    max_retries_m = RST_MAX_RETRIES;
    base_port_m = RST_BASE_PORT;
  endfunction

  // Applies one accepted command word to the model and queues the result it causes.
  function automatic void table_predict(input logic [2:0] cmd, input logic [7:0] seq,
                                        input logic [15:0] handle, input logic [15:0] port);
    result_t     r;
    logic [7:0]  idx;
    logic [31:0] age;
    logic [63:0] lim;
    logic [3:0]  tries;
    case (cmd)
      CMD_ADD: begin
        if (run_m && !tbl_valid[seq]) begin
          tbl_valid[seq] = 1'b1;
          tbl_sent[seq] = clock_ms;
          tbl_retries[seq] = '0;
          tbl_port[seq] = port;
          tbl_handle[seq] = handle;
        end
      end
      CMD_ACK: begin
        if (run_m && !base_m) tbl_valid[seq] = 1'b0;
      end
      CMD_NAK: begin
        if (run_m && base_m && tbl_valid[seq]) begin
          r.seq = seq;
          r.handle = tbl_handle[seq];
          r.port = tbl_port[seq];
          r.action = ACT_NAK;
          r.sweep_end = 1'b0;
          due_results = {due_results, r};
        end
      end
      CMD_TICK: clock_ms = clock_ms + 32'd1;
      CMD_POLL: begin
        if (run_m) begin
          idx = sweep_ptr;
          sweep_ptr = sweep_ptr + 8'd1;
          r.seq = idx;
          r.handle = '0;
          r.port = '0;
          r.action = ACT_NONE;
          r.sweep_end = (idx == 8'hFF);
          if (tbl_valid[idx] && !base_m) begin
            age = clock_ms - tbl_sent[idx];
            tries = tbl_retries[idx];
            lim = {48'd0, timeout_m} << tries;
            if ({32'd0, age} > lim) begin
              r.handle = tbl_handle[idx];
              r.port = tbl_port[idx];
              if (tries >= max_retries_m) begin
                tbl_valid[idx] = 1'b0;
                r.action = (tbl_port[idx] == base_port_m) ? ACT_GIVEUP_BASE : ACT_GIVEUP_OTHER;
              end else begin
                tbl_sent[idx] = clock_ms;
                tbl_retries[idx] = tries + 4'd1;
                r.action = ACT_TIMEOUT;
              end
            end
          end
          due_results = {due_results, r};
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < 256; i++) tbl_valid[i] = 1'b0;
        sweep_ptr = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: out_seq %0d, out_action %0d", out_seq, out_action);
        err_count++;
      end else begin
        got_exp = due_results.pop_front();
        check_field("out_seq", got_exp.seq, out_seq);
        check_field("out_handle", got_exp.handle, out_handle);
        check_field("out_port", got_exp.port, out_port);
        check_field("out_action", got_exp.action, out_action);
        check_field("out_sweep_end", got_exp.sweep_end, out_sweep_end);
      end
    end
  end

  // Receiver: a long hold when the test asks for one, otherwise segments of random stall mode.
  always @(negedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      end
      seg_left--;
      case (stall_mode)
        STALL_NONE:  out_stall = 1'b0;
        STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
        default:     out_stall = ~out_stall;
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after the word was taken.
  task automatic send_word(input logic [2:0] cmd, input logic [7:0] seq,
                           input logic [15:0] handle, input logic [15:0] port);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_cmd = cmd;
    in_seq = seq;
    in_packet_handle = handle;
    in_recipient_port = port;
    do @(posedge clk); while (in_stall);
    table_predict(cmd, seq, handle, port);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_RUNNING:     run_m = data[0];
      CFG_ROLE_BASE:   base_m = data[0];
      CFG_TIMEOUT:     timeout_m = data;
      CFG_MAX_RETRIES: max_retries_m = data[3:0];
      CFG_BASE_PORT:   base_port_m = data;
      default: ;
    endcase
  endtask

  // Wait until every expected word has come out, then let the block finish its last word
  // and any clearing pass.
  task automatic settle();
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  // Random traffic. Adds mostly land just ahead of the sweep pointer and acks and naks mostly
  // target recent adds, so that polls soon find live entries.
  task automatic run_traffic(input int n, input int nak_pct);
    int unsigned pick;
    logic [2:0]  cmd;
    logic [7:0]  seq;
    logic [15:0] port;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 199);
      seq = 8'($urandom);
      port = ($urandom_range(0, 3) == 0) ? base_port_m : 16'($urandom);
      if (pick < 2) begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_UNDEF_LO : CMD_UNDEF_HI;
      end else if (pick < 3) begin
        cmd = CMD_CLEAR;
      end else if (pick < 43) begin
        cmd = CMD_ADD;
        if ($urandom_range(0, 4) != 0) seq = sweep_ptr + 8'($urandom_range(1, 48));
      end else if (pick < 53 + 2 * nak_pct) begin
        cmd = (pick < 53) ? CMD_ACK : CMD_NAK;
        if (recent_seqs.size() > 0 && $urandom_range(0, 4) != 0)
          seq = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
      end else if (pick < 73 + 2 * nak_pct) begin
        cmd = CMD_TICK;
      end else begin
        cmd = CMD_POLL;
      end
      send_word(cmd, seq, 16'($urandom), port);
      if (cmd == CMD_ADD) begin
        recent_seqs = {recent_seqs, seq};
        if (recent_seqs.size() > 16) void'(recent_seqs.pop_front());
      end
    end
  endtask

  // With the reset settings the manager is stopped: only tick acts.
  task automatic test_idle_commands();
    send_word(CMD_ADD, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_NAK, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_POLL, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_ACK, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_TICK, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_UNDEF_LO, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_word(CMD_UNDEF_HI, 8'hFF, 16'hFFFF, 16'hFFFF);
    settle();
  endtask

  task automatic test_rover_directed();
    write_reg(CFG_RUNNING, 16'd1);
    write_reg(CFG_ROLE_BASE, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_MAX_RETRIES, 16'd0);
    write_reg(CFG_BASE_PORT, 16'hFFFF);
    send_word(CMD_ADD, 8'd0, 16'hFFFF, 16'hFFFF);
    send_word(CMD_ADD, 8'd0, 16'h1234, 16'h5678);
    send_word(CMD_ADD, 8'd1, 16'h0000, 16'h0000);
    send_word(CMD_ADD, 8'd2, 16'hAAAA, 16'h5555);
    send_word(CMD_ACK, 8'd2, 16'h0000, 16'h0000);
    send_word(CMD_NAK, 8'd1, 16'h0000, 16'h0000);
    send_word(CMD_TICK, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_TICK, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_POLL, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_POLL, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_POLL, 8'd0, 16'h0000, 16'h0000);
    settle();
  endtask

  task automatic test_base_directed();
    write_reg(CFG_ROLE_BASE, 16'd1);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_MAX_RETRIES, 16'd15);
    write_reg(CFG_BASE_PORT, 16'd0);
    send_word(CMD_ADD, 8'd9, 16'h0F0F, 16'hF0F0);
    send_word(CMD_NAK, 8'd9, 16'h0000, 16'h0000);
    send_word(CMD_NAK, 8'd10, 16'h0000, 16'h0000);
    send_word(CMD_ACK, 8'd9, 16'h0000, 16'h0000);
    send_word(CMD_NAK, 8'd9, 16'h0000, 16'h0000);
    send_word(CMD_POLL, 8'd0, 16'h0000, 16'h0000);
    send_word(CMD_CLEAR, 8'd0, 16'h0000, 16'h0000);
    settle();
  endtask

  task automatic test_rover_backoff();
    write_reg(CFG_ROLE_BASE, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_MAX_RETRIES, 16'd2);
    write_reg(CFG_BASE_PORT, 16'($urandom));
    run_traffic(170, 5);
    settle();
  endtask

  task automatic test_long_retry();
    write_reg(CFG_TIMEOUT, 16'd3);
    write_reg(CFG_MAX_RETRIES, 16'd15);
    run_traffic(130, 5);
    settle();
  endtask

  // Entries that already retried as often as the new limit or more are given up at their next timeout.
  task automatic test_lowered_limit();
    write_reg(CFG_TIMEOUT, 16'd2);
    write_reg(CFG_MAX_RETRIES, 16'd0);
    run_traffic(110, 5);
    settle();
  endtask

  task automatic test_base_naks();
    write_reg(CFG_ROLE_BASE, 16'd1);
    run_traffic(110, 25);
    settle();
  endtask

  task automatic test_stopped();
    write_reg(CFG_RUNNING, 16'd0);
    run_traffic(30, 10);
    settle();
  endtask

  // The receiver holds off long enough that results back up into the input side.
  task automatic test_backpressure();
    write_reg(CFG_RUNNING, 16'd1);
    write_reg(CFG_ROLE_BASE, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_MAX_RETRIES, 16'd15);
    write_reg(CFG_BASE_PORT, 16'd0);
    hold_asked++;
    run_traffic(80, 5);
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = CMD_TICK;
    in_seq = '0;
    in_packet_handle = '0;
    in_recipient_port = '0;
    model_reset();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_idle_commands();
    test_rover_directed();
    test_base_directed();
    test_rover_backoff();
    test_long_retry();
    test_lowered_limit();
    test_base_naks();
    test_stopped();
    test_backpressure();

    repeat (20) @(posedge clk);
    if (err_count == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/arq_pkg.sv
hdl/arq_ctrl.sv
hdl/arq_dp.sv
hdl/arq_retransmit_table_top.sv
hdl/arq_checker.sv
verif/tb_arq_retransmit_table_top.sv
